FILE: sv/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the stable min priority queue unit.
// ----------------------------------------------------------------------------
package smpq_pkg;

    // Field widths of the command and response transactions
    localparam int ID_BITS   = 16;
    localparam int COST_BITS = 32;
    localparam int CNT_BITS  = 7;
    localparam int DEPTH_DEF = 64;

    // Opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [ID_BITS-1:0]   node_id;
        logic [COST_BITS-1:0] new_cost;
    } cmd_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   out_id;
        logic [COST_BITS-1:0] out_cost;
        logic                 found;
        logic [1:0]           status;
        logic                 is_empty;
        logic [CNT_BITS-1:0]  entry_count;
    } rsp_t;

    // One stored queue entry
    typedef struct packed {
        logic [COST_BITS-1:0] key;
        logic [ID_BITS-1:0]   ident;
    } entry_t;

    // Compare unit result
    typedef struct packed {
        logic key_gt;
        logic id_eq;
    } cmp_t;

endpackage

FILE: sv/stable_min_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue_unit
// Sorted open-set queue of (id, cost) entries with pop-min, insert, update
// and query. Entries sit sorted by cost in a RAM; a small sequencer walks
// them with one shared compare unit.
// ----------------------------------------------------------------------------
//  channel    ports                 handshake
//  command    cmd (cmd_t)           start & !busy accepts the transaction
//  response   rsp (rsp_t)           done high for one cycle, always taken
//
//  Each entry visited takes a RAM read, then a compare (insert, search)
//  and/or a write (insert, shift). Insert walks down from the tail moving
//  larger keys up; pop reads the head, then shifts the rest down. Query and
//  update search from the front; a found update shifts the entries behind it down, then does the insert walk.
//  Pop on empty and insert when full answer next cycle; busy stays low.
//  Reset clears the registers, not the RAM; done follows the last busy cycle.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_unit #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  smpq_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output smpq_pkg::rsp_t rsp
);
    import smpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = COST_BITS + ID_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_CAP,
        S_INS_RD,
        S_INS_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_FND_RD,
        S_FND_CMP
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [1:0]           op_reg, op_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [COST_BITS-1:0] cost_reg, cost_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 done_reg, done_next;

    logic                 ram_wr, ram_rd;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    entry_t               ram_wdata, ram_rdata;
    cmp_t                 cmp;
    logic [CW-1:0]        ptr_m1;
    logic                 fin;

    // Entry storage
    smpq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_rd),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Shared compare unit
    smpq_cmp u_cmp (
        .entry (ram_rdata),
        .key   (cost_reg),
        .ident (id_reg),
        .res   (cmp)
    );

    assign ptr_m1 = ptr_reg - 1'b1;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        cost_next  = cost_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        ram_wr     = 1'b0;
        ram_rd     = 1'b0;
        ram_waddr  = '0;
        ram_raddr  = '0;
        ram_wdata  = '0;
        fin        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = cmd.opcode;
                    id_next   = cmd.node_id;
                    cost_next = cmd.new_cost;
                    rsp_next  = '0;
                    case (cmd.opcode)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                                fin             = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = cnt_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        OP_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_next.status = ST_EMPTY;
                                fin             = 1'b1;
                            end
                            else
                            begin
                                ram_rd     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_POP_CAP;
                            end
                        end
                        default:
                        begin
                            ptr_next   = '0;
                            state_next = S_FND_RD;
                        end
                    endcase
                end
            end

            // Head entry read back: capture it, then close the gap
            S_POP_CAP:
            begin
                rsp_next.out_id   = ram_rdata.ident;
                rsp_next.out_cost = ram_rdata.key;
                rsp_next.found    = 1'b1;
                ptr_next          = CW'(1);
                state_next        = S_SHF_RD;
            end

            // Walk down from the tail, moving larger keys up one slot
            S_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    ram_wr          = 1'b1;
                    ram_waddr       = '0;
                    ram_wdata.key   = cost_reg;
                    ram_wdata.ident = id_reg;
                    cnt_next        = cnt_reg + 1'b1;
                    fin             = 1'b1;
                end
                else
                begin
                    ram_rd     = 1'b1;
                    ram_raddr  = ptr_m1[AW-1:0];
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                ram_wr    = 1'b1;
                ram_waddr = ptr_reg[AW-1:0];
                if (cmp.key_gt)
                begin
                    ram_wdata  = ram_rdata;
                    ptr_next   = ptr_m1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    ram_wdata.key   = cost_reg;
                    ram_wdata.ident = id_reg;
                    cnt_next        = cnt_reg + 1'b1;
                    fin             = 1'b1;
                end
            end

            // Shift entries down one slot from ptr to the tail
            S_SHF_RD:
            begin
                if (ptr_reg >= cnt_reg)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (op_reg == OP_UPDATE)
                    begin
                        ptr_next   = cnt_reg - 1'b1;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else
                begin
                    ram_rd     = 1'b1;
                    ram_raddr  = ptr_reg[AW-1:0];
                    state_next = S_SHF_WR;
                end
            end

            S_SHF_WR:
            begin
                ram_wr     = 1'b1;
                ram_waddr  = ptr_m1[AW-1:0];
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_reg + 1'b1;
                state_next = S_SHF_RD;
            end

            // Search from the front for the identifier
            S_FND_RD:
            begin
                if (ptr_reg >= cnt_reg)
                begin
                    if (op_reg == OP_UPDATE)
                    begin
                        rsp_next.status = ST_ABSENT;
                    end
                    fin = 1'b1;
                end
                else
                begin
                    ram_rd     = 1'b1;
                    ram_raddr  = ptr_reg[AW-1:0];
                    state_next = S_FND_CMP;
                end
            end

            S_FND_CMP:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (cmp.id_eq)
                begin
                    rsp_next.found = 1'b1;
                    if (op_reg == OP_QUERY)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SHF_RD;
                    end
                end
                else
                begin
                    state_next = S_FND_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Close the transaction: counts after the operation, one-cycle strobe
        if (fin)
        begin
            rsp_next.is_empty    = (cnt_next == '0);
            rsp_next.entry_count = CNT_BITS'(cnt_next);
            done_next            = 1'b1;
            state_next           = S_IDLE;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            ptr_reg   <= '0;
            op_reg    <= '0;
            id_reg    <= '0;
            cost_reg  <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            ptr_reg   <= ptr_next;
            op_reg    <= op_next;
            id_reg    <= id_next;
            cost_reg  <= cost_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Assertions
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr && ram_rd))
        else $error("RAM read and write in the same cycle");

    a_start_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither worked on nor answered");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("response without a transaction");

endmodule

FILE: sv/smpq_ram.sv
// ----------------------------------------------------------------------------
// smpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/smpq_cmp.sv
// ----------------------------------------------------------------------------
// smpq_cmp
// Shared compare unit: key order for insertion, identifier match for search.
// ----------------------------------------------------------------------------
module smpq_cmp (
    input  smpq_pkg::entry_t                     entry,
    input  logic [smpq_pkg::COST_BITS-1:0]       key,
    input  logic [smpq_pkg::ID_BITS-1:0]         ident,
    output smpq_pkg::cmp_t                       res
);
    import smpq_pkg::*;

    // Stored key strictly greater: entry moves up, equal keys stay in front
    assign res.key_gt = (entry.key > key);
    assign res.id_eq  = (entry.ident == ident);

endmodule
